[hw/rtl/c8ie_pkg.sv]
package c8ie_pkg;

  typedef enum logic [3:0] {
    CLS_SYS,
    CLS_NONE,
    CLS_RET,
    CLS_JP,
    CLS_CALL,
    CLS_SE_K,
    CLS_SNE_K,
    CLS_SE_R,
    CLS_SNE_R,
    CLS_LD_K,
    CLS_ADD_K,
    CLS_ALU,
    CLS_LD_I,
    CLS_JP_V0,
    CLS_RND
  } cls_e;

  typedef enum logic [3:0] {
    ALU_MOV  = 4'h0,
    ALU_OR   = 4'h1,
    ALU_AND  = 4'h2,
    ALU_XOR  = 4'h3,
    ALU_ADD  = 4'h4,
    ALU_SUB  = 4'h5,
    ALU_SHR  = 4'h6,
    ALU_SUBN = 4'h7,
    ALU_SHL  = 4'hE
  } alu_e;

  typedef struct packed {
    cls_e        cls;
    alu_e        alu;
    logic [3:0]  x;
    logic [3:0]  y;
    logic [11:0] nnn;
    logic [7:0]  rnd;
  } instr_t;

  typedef struct packed {
    logic [3:0] x;
    logic [3:0] y;
  } rd_addr_t;

  localparam logic [11:0] PC_RESET = 12'h200;
  localparam logic [15:0] OP_CLS   = 16'h00E0;
  localparam logic [15:0] OP_RET   = 16'h00EE;
  localparam logic [3:0]  VF_IDX   = 4'hF;
  localparam logic [3:0]  V0_IDX   = 4'h0;

endpackage

[hw/rtl/c8ie_front.sv]
module c8ie_front (
  input  logic [15:0]     opcode_i,
  input  logic [7:0]      random_byte_i,
  output c8ie_pkg::instr_t instr_o
);
  import c8ie_pkg::*;

  always_comb begin
    instr_o.cls = CLS_NONE;
    instr_o.alu = ALU_MOV;
    instr_o.x   = opcode_i[11:8];
    instr_o.y   = opcode_i[7:4];
    instr_o.nnn = opcode_i[11:0];
    instr_o.rnd = random_byte_i;
    unique case (opcode_i[15:12])
      4'h0: begin
        priority if (opcode_i == OP_CLS) instr_o.cls = CLS_NONE;
        else if (opcode_i == OP_RET) instr_o.cls = CLS_RET;
        else instr_o.cls = CLS_SYS;
      end
      4'h1: instr_o.cls = CLS_JP;
      4'h2: instr_o.cls = CLS_CALL;
      4'h3: instr_o.cls = CLS_SE_K;
      4'h4: instr_o.cls = CLS_SNE_K;
      4'h5: instr_o.cls = CLS_SE_R;
      4'h6: instr_o.cls = CLS_LD_K;
      4'h7: instr_o.cls = CLS_ADD_K;
      4'h8: begin
        unique case (opcode_i[3:0])
          4'h0, 4'h1, 4'h2, 4'h3, 4'h4, 4'h5, 4'h6, 4'h7, 4'hE: begin
            instr_o.cls = CLS_ALU;
            instr_o.alu = alu_e'(opcode_i[3:0]);
          end
          default: instr_o.cls = CLS_NONE;
        endcase
      end
      4'h9: instr_o.cls = CLS_SNE_R;
      4'hA: instr_o.cls = CLS_LD_I;
      4'hB: instr_o.cls = CLS_JP_V0;
      4'hC: instr_o.cls = CLS_RND;
      default: instr_o.cls = CLS_NONE;
    endcase
  end

endmodule

[hw/rtl/c8ie_queue.sv]
module c8ie_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_valid_i,
  output logic               push_ready_o,
  input  c8ie_pkg::instr_t   push_data_i,
  output logic               head_valid_o,
  output c8ie_pkg::instr_t   head_o,
  input  logic               pop_i,
  output c8ie_pkg::rd_addr_t next_addr_o
);
  import c8ie_pkg::*;

  logic [1:0] count_d, count_q;
  instr_t     e0_q, e1_q;
  logic       push;

  assign push_ready_o = (count_q != 2'd2);
  assign push         = push_valid_i && push_ready_o;
  assign head_valid_o = (count_q != 2'd0);
  assign head_o       = e0_q;

  // address of the entry that heads the queue after this edge
  always_comb begin
    priority if (pop_i && (count_q == 2'd2)) begin
      next_addr_o.x = e1_q.x;
      next_addr_o.y = e1_q.y;
    end else if (!pop_i && (count_q != 2'd0)) begin
      next_addr_o.x = e0_q.x;
      next_addr_o.y = e0_q.y;
    end else begin
      next_addr_o.x = push_data_i.x;
      next_addr_o.y = push_data_i.y;
    end
  end

  always_comb begin
    count_d = count_q + {1'b0, push} - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= 2'd0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_i) begin
      if (count_q == 2'd2) begin
        e0_q <= e1_q;
      end else if (push) begin
        e0_q <= push_data_i;
      end
    end else if (push) begin
      if (count_q == 2'd0) begin
        e0_q <= push_data_i;
      end else begin
        e1_q <= push_data_i;
      end
    end
  end

endmodule

[hw/rtl/c8ie_back.sv]
module c8ie_back #(
  parameter int STACK_DEPTH = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  input  logic [11:0]        cfg_data_i,
  input  logic               head_valid_i,
  input  c8ie_pkg::instr_t   head_i,
  output logic               pop_o,
  input  c8ie_pkg::rd_addr_t next_addr_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [11:0]        next_pc_o,
  output logic               reg_written_o,
  output logic [3:0]         reg_index_o,
  output logic [7:0]         reg_value_o,
  output logic               flag_written_o,
  output logic               flag_value_o,
  output logic [11:0]        index_value_o,
  output logic               handled_o,
  output logic               stack_fault_o
);
  import c8ie_pkg::*;

  localparam int AW  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int SPW = $clog2(STACK_DEPTH + 1);

  logic [11:0]    pc_q, i_q, i_d, npc, pc2, pc4, tos_q, tos_d, below_q;
  logic [SPW-1:0] sp_q, sp_d, sp_nx, sp_rd;
  logic [AW-1:0]  stk_rd_addr;
  logic [11:0]    stk [STACK_DEPTH];
  logic [7:0]     rf [16];
  logic [15:0]    rf_vld_q;
  logic [7:0]     rx_q, ry_q, vx, vy, vf_q, v0_q, kk, val;
  logic [8:0]     sum;
  logic           fire, wr, fw, flag, handled, fault, push, rf_we;
  logic           out_valid_q;

  assign fire        = head_valid_i && (!out_valid_q || out_ready_i);
  assign pop_o       = fire;
  assign out_valid_o = out_valid_q;

  assign vx  = (head_i.x == VF_IDX) ? vf_q : rx_q;
  assign vy  = (head_i.y == VF_IDX) ? vf_q : ry_q;
  assign kk  = head_i.nnn[7:0];
  assign pc2 = pc_q + 12'd2;
  assign pc4 = pc_q + 12'd4;
  assign sum = {1'b0, vx} + {1'b0, vy};

  always_comb begin
    npc     = pc2;
    wr      = 1'b0;
    fw      = 1'b0;
    val     = 8'd0;
    flag    = 1'b0;
    handled = 1'b1;
    fault   = 1'b0;
    push    = 1'b0;
    i_d     = i_q;
    sp_d    = sp_q;
    tos_d   = tos_q;
    unique case (head_i.cls)
      CLS_SYS, CLS_JP: npc = head_i.nnn;
      CLS_NONE: handled = 1'b0;
      CLS_RET: begin
        if (sp_q == '0) begin
          fault = 1'b1;
        end else begin
          sp_d  = sp_q - SPW'(1);
          npc   = tos_q + 12'd2;
          tos_d = below_q;
        end
      end
      CLS_CALL: begin
        if (sp_q == SPW'(STACK_DEPTH)) begin
          fault = 1'b1;
        end else begin
          push  = 1'b1;
          tos_d = pc_q;
          sp_d  = sp_q + SPW'(1);
          npc   = head_i.nnn;
        end
      end
      CLS_SE_K:  if (vx == kk) npc = pc4;
      CLS_SNE_K: if (vx != kk) npc = pc4;
      CLS_SE_R:  if (vx == vy) npc = pc4;
      CLS_SNE_R: if (vx != vy) npc = pc4;
      CLS_LD_K: begin
        wr  = 1'b1;
        val = kk;
      end
      CLS_ADD_K: begin
        wr  = 1'b1;
        val = vx + kk;
      end
      CLS_ALU: begin
        wr = 1'b1;
        unique case (head_i.alu)
          ALU_MOV: val = vy;
          ALU_OR:  val = vx | vy;
          ALU_AND: val = vx & vy;
          ALU_XOR: val = vx ^ vy;
          ALU_ADD: begin
            val  = sum[7:0];
            fw   = 1'b1;
            flag = sum[8];
          end
          ALU_SUB: begin
            val  = vx - vy;
            fw   = 1'b1;
            flag = (vx >= vy);
          end
          ALU_SHR: begin
            val  = {1'b0, vx[7:1]};
            fw   = 1'b1;
            flag = vx[0];
          end
          ALU_SUBN: begin
            val  = vy - vx;
            fw   = 1'b1;
            flag = (vy >= vx);
          end
          ALU_SHL: begin
            val  = {vx[6:0], 1'b0};
            fw   = 1'b1;
            flag = vx[7];
          end
          default: begin
            wr      = 1'b0;
            handled = 1'b0;
          end
        endcase
      end
      CLS_LD_I:  i_d = head_i.nnn;
      CLS_JP_V0: npc = head_i.nnn + {4'd0, v0_q};
      CLS_RND: begin
        wr  = 1'b1;
        val = head_i.rnd & kk;
      end
      default: handled = 1'b0;
    endcase
  end

  assign rf_we       = fire && wr && (head_i.x != VF_IDX);
  assign sp_nx       = fire ? sp_d : sp_q;
  assign sp_rd       = sp_nx - SPW'(2);
  assign stk_rd_addr = sp_rd[AW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q        <= PC_RESET;
      i_q         <= 12'd0;
      sp_q        <= '0;
      vf_q        <= 8'd0;
      v0_q        <= 8'd0;
      rf_vld_q    <= 16'd0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        pc_q <= cfg_data_i;
      end else if (fire) begin
        pc_q <= npc;
      end
      if (fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (fire) begin
        i_q  <= i_d;
        sp_q <= sp_d;
        if (fw) begin
          vf_q <= {7'd0, flag};
        end else if (wr && (head_i.x == VF_IDX)) begin
          vf_q <= val;
        end
        if (wr && (head_i.x == V0_IDX)) begin
          v0_q <= val;
        end
      end
      if (rf_we) begin
        rf_vld_q[head_i.x] <= 1'b1;
      end
    end
  end

  // register file: one write, two registered reads with write forwarding
  always_ff @(posedge clk_i) begin
    if (rf_we) begin
      rf[head_i.x] <= val;
    end
    if (rf_we && (head_i.x == next_addr_i.x)) begin
      rx_q <= val;
    end else if (!rf_vld_q[next_addr_i.x]) begin
      rx_q <= 8'd0;
    end else begin
      rx_q <= rf[next_addr_i.x];
    end
    if (rf_we && (head_i.x == next_addr_i.y)) begin
      ry_q <= val;
    end else if (!rf_vld_q[next_addr_i.y]) begin
      ry_q <= 8'd0;
    end else begin
      ry_q <= rf[next_addr_i.y];
    end
  end

  // return stack: top held in a register, entry below prefetched
  always_ff @(posedge clk_i) begin
    if (fire && push) begin
      stk[sp_q[AW-1:0]] <= pc_q;
    end
    below_q <= stk[stk_rd_addr];
    if (fire) begin
      tos_q <= tos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      next_pc_o      <= npc;
      reg_written_o  <= wr;
      reg_index_o    <= wr ? head_i.x : 4'd0;
      reg_value_o    <= wr ? val : 8'd0;
      flag_written_o <= fw;
      flag_value_o   <= fw && flag;
      index_value_o  <= i_d;
      handled_o      <= handled;
      stack_fault_o  <= fault;
    end
  end

endmodule

[hw/rtl/chip8_instruction_execute_core.sv]
// CHIP-8 execute core: one instruction word in, one result beat out. A new
// instruction is taken every cycle while the two-entry queue between the
// decoder and the execute stage has room; the execute stage retires one
// instruction per cycle while the output is not stalled, so sustained
// throughput is one instruction per clock while out_ready_i stays high.
// The execute stage reads Vx and Vy from a registered register file with
// forwarding of the previous write, and keeps the top of the return stack in
// a register. Writing cfg_data_i loads the program counter; write it only
// while no instruction is in flight.
module chip8_instruction_execute_core #(
  parameter int STACK_DEPTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [11:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [15:0] opcode_i,
  input  logic [7:0]  random_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [11:0] next_pc_o,
  output logic        reg_written_o,
  output logic [3:0]  reg_index_o,
  output logic [7:0]  reg_value_o,
  output logic        flag_written_o,
  output logic        flag_value_o,
  output logic [11:0] index_value_o,
  output logic        handled_o,
  output logic        stack_fault_o
);
  import c8ie_pkg::*;

  instr_t   dec_instr, head;
  rd_addr_t next_addr;
  logic     head_valid, pop;

  assign cfg_ready_o = 1'b1;

  c8ie_front u_front (
    .opcode_i      (opcode_i),
    .random_byte_i (random_byte_i),
    .instr_o       (dec_instr)
  );

  c8ie_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (in_valid_i),
    .push_ready_o (in_ready_o),
    .push_data_i  (dec_instr),
    .head_valid_o (head_valid),
    .head_o       (head),
    .pop_i        (pop),
    .next_addr_o  (next_addr)
  );

  c8ie_back #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_data_i     (cfg_data_i),
    .head_valid_i   (head_valid),
    .head_i         (head),
    .pop_o          (pop),
    .next_addr_i    (next_addr),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .next_pc_o      (next_pc_o),
    .reg_written_o  (reg_written_o),
    .reg_index_o    (reg_index_o),
    .reg_value_o    (reg_value_o),
    .flag_written_o (flag_written_o),
    .flag_value_o   (flag_value_o),
    .index_value_o  (index_value_o),
    .handled_o      (handled_o),
    .stack_fault_o  (stack_fault_o)
  );

endmodule

[hw/rtl/c8ie_checker.sv]
module c8ie_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [11:0] next_pc_o,
  input logic        reg_written_o,
  input logic [3:0]  reg_index_o,
  input logic [7:0]  reg_value_o,
  input logic        flag_written_o,
  input logic        handled_o,
  input logic        stack_fault_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(next_pc_o))
    else $error("result beat dropped or changed while stalled");

  a_flag_needs_reg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && flag_written_o |-> reg_written_o && handled_o)
    else $error("flag write without register write");

  a_unhandled_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !handled_o |-> !reg_written_o && !flag_written_o && !stack_fault_o)
    else $error("unhandled instruction changed state");

  a_no_write_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !reg_written_o |-> (reg_index_o == 4'd0) && (reg_value_o == 8'd0))
    else $error("register fields nonzero without write");

  a_fault_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && stack_fault_o |-> !reg_written_o && handled_o)
    else $error("stack fault with register write");

endmodule

bind chip8_instruction_execute_core c8ie_checker u_c8ie_checker (.*);
